// ----- rtl/rdse_pkg.sv -----
package rdse_pkg;

   // Widths fixed by the data format
   localparam int CHAR_W    = 8;
   localparam int DIGIT_W   = 4;
   localparam int RADIX_W   = 5;
   localparam int TABLE_W   = 64;
   localparam int CSR_IDX_W = 2;

   // Quotient bits produced per divider cycle
   localparam int CHUNK_W = 8;

   // Defaults for the top-level parameters
   localparam int DEFAULT_VALUE_WIDTH = 32;
   localparam int DEFAULT_MAX_RADIX   = 16;

   // Fixed characters and reset values
   localparam logic [CHAR_W-1:0]  ZERO_CHAR        = 8'h30;
   localparam logic [RADIX_W-1:0] RESET_RADIX      = 5'd10;
   localparam logic [RADIX_W-1:0] MIN_RADIX        = 5'd2;
   localparam logic [TABLE_W-1:0] RESET_CHARS_LOW  = 64'h3736353433323130;
   localparam logic [TABLE_W-1:0] RESET_CHARS_HIGH = 64'h6665646362613938;

   // Register indexes on the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RADIX      = 2'd0,
      CSR_CHARS_LOW  = 2'd1,
      CSR_CHARS_HIGH = 2'd2
   } csr_index_type;

   // Map a digit value to its character through the 16-entry table
   function automatic logic [CHAR_W-1:0] digit_char(
      input logic [DIGIT_W-1:0] digit,
      input logic [TABLE_W-1:0] chars_low,
      input logic [TABLE_W-1:0] chars_high
   );
      logic [2*TABLE_W-1:0] tbl;
      tbl = {chars_high, chars_low};
      return tbl[{digit, 3'b000} +: CHAR_W];
   endfunction

endpackage

// ----- rtl/rdse_front.sv -----
module rdse_front
   import rdse_pkg::*;
#(
   parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   // input word channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [VALUE_WIDTH-1:0] req_value,
   // queue head toward the back end
   output logic                   q_valid,
   input  logic                   q_ready,
   output logic [VALUE_WIDTH-1:0] q_value,
   output logic                   q_zero
);

   // two-entry queue: value plus zero flag
   logic [VALUE_WIDTH-1:0] value_q_ff [2];
   logic                   zero_q_ff  [2];
   logic                   wr_ptr_ff, wr_ptr_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   logic [1:0]             count_ff, count_in;
   logic                   push, pop;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid & ~req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign pop       = q_valid & q_ready;
   assign q_value   = value_q_ff[rd_ptr_ff];
   assign q_zero    = zero_q_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // classify on entry: zero takes the short path in the back end
   always_ff @(posedge clock) begin
      if (push) begin
         value_q_ff[wr_ptr_ff] <= req_value;
         zero_q_ff[wr_ptr_ff]  <= (req_value == '0);
      end
   end

endmodule

// ----- rtl/rdse_divider.sv -----
module rdse_divider
   import rdse_pkg::*;
#(
   parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] dividend,
   input  logic [RADIX_W-1:0]     radix,
   output logic                   done,
   output logic [VALUE_WIDTH-1:0] quotient,
   output logic [DIGIT_W-1:0]     remainder
);

   localparam int NCHUNK = (VALUE_WIDTH + CHUNK_W - 1) / CHUNK_W;
   localparam int PAD_W  = NCHUNK * CHUNK_W;
   localparam int STEP_W = $clog2(NCHUNK + 1);

   // work holds remaining dividend bits on top, quotient bits shifting in below
   logic [PAD_W-1:0]   work_ff, work_in;
   logic [DIGIT_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CHUNK_W-1:0] chunk;
   logic [CHUNK_W-1:0] qchunk;
   logic [DIGIT_W-1:0] rem_v;
   logic [DIGIT_W:0]   trial;

   // restoring division, one chunk of dividend bits per cycle
   always_comb begin
      chunk  = work_ff[PAD_W-1 -: CHUNK_W];
      rem_v  = rem_ff;
      qchunk = '0;
      trial  = '0;
      for (int i = CHUNK_W - 1; i >= 0; i--) begin
         trial = {rem_v, chunk[i]};
         if (trial >= radix) begin
            rem_v     = DIGIT_W'(trial - radix);
            qchunk[i] = 1'b1;
         end else begin
            rem_v = trial[DIGIT_W-1:0];
         end
      end
   end

   // load / iterate control
   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         work_in = PAD_W'(dividend);
         rem_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         work_in = (work_ff << CHUNK_W) | PAD_W'(qchunk);
         rem_in  = rem_v;
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(NCHUNK - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = work_ff[VALUE_WIDTH-1:0];
   assign remainder = rem_ff;

endmodule

// ----- rtl/rdse_back.sv -----
module rdse_back
   import rdse_pkg::*;
#(
   parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   // queue head from the front end
   input  logic                   q_valid,
   output logic                   q_ready,
   input  logic [VALUE_WIDTH-1:0] q_value,
   input  logic                   q_zero,
   // divider
   output logic                   div_start,
   output logic [VALUE_WIDTH-1:0] div_dividend,
   input  logic                   div_done,
   input  logic [VALUE_WIDTH-1:0] div_quot,
   input  logic [DIGIT_W-1:0]     div_rem,
   // digit table
   input  logic [TABLE_W-1:0]     chars_low,
   input  logic [TABLE_W-1:0]     chars_high,
   // result word channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [CHAR_W-1:0]      rsp_char_out,
   output logic                   rsp_last_char
);

   localparam int IDX_W = $clog2(VALUE_WIDTH);
   localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_READ = 4'b0100,
      ST_SHOW = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               zero_ff, zero_in;
   logic [DIGIT_W-1:0] digit_q_ff;
   logic               mem_we, mem_re;
   logic               last;

   // remainders, least significant digit at entry 0
   logic [DIGIT_W-1:0] digit_store [VALUE_WIDTH];

   assign q_ready      = (state_ff == ST_IDLE);
   assign rsp_valid    = (state_ff == ST_SHOW);
   assign last         = zero_ff | (rd_idx_ff == '0);
   assign div_dividend = (state_ff == ST_IDLE) ? q_value : div_quot;
   assign mem_we       = (state_ff == ST_DIV) & div_done;
   assign mem_re       = (state_ff == ST_READ);

   // sequencer: divide out digits, then play them back in reverse; a zero word skips the divider
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      rd_idx_in = rd_idx_ff;
      zero_in   = zero_ff;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               zero_in = q_zero;
               cnt_in  = '0;
               if (q_zero) begin
                  state_in = ST_SHOW;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               cnt_in = cnt_ff + CNT_W'(1);
               if (div_quot == '0) begin
                  rd_idx_in = cnt_ff[IDX_W-1:0];
                  state_in  = ST_READ;
               end else begin
                  div_start = 1'b1;
               end
            end
         end
         ST_READ: begin
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (!rsp_stall) begin
               if (last) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff - IDX_W'(1);
                  state_in  = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         rd_idx_ff <= '0;
         zero_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         rd_idx_ff <= rd_idx_in;
         zero_ff   <= zero_in;
      end
   end

   // digit memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         digit_store[cnt_ff[IDX_W-1:0]] <= div_rem;
      end
      if (mem_re) begin
         digit_q_ff <= digit_store[rd_idx_ff];
      end
   end

   // zero always shows as the ASCII digit, not through the table
   assign rsp_char_out  = zero_ff ? ZERO_CHAR : digit_char(digit_q_ff, chars_low, chars_high);
   assign rsp_last_char = last;

endmodule

// ----- rtl/radix_digit_string_encoder.sv -----
// A zero word goes from the input queue straight to the show state, skipping the divider;
// otherwise each digit takes one divider pass over ceil(VALUE_WIDTH/8) 8-bit chunks, and
// each character then passes a registered digit memory read and a show state.
// Throughput is set by the 8-bit-per-cycle divider and the registered digit memory read.
// A two-word input queue takes new words while the back end works.
// Reset (synchronous): queue and sequencer empty, radix 10, table "0123456789abcdef".
module radix_digit_string_encoder
   import rdse_pkg::*;
#(
   parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH,
   parameter int MAX_RADIX   = DEFAULT_MAX_RADIX
) (
   input  logic                   clock,
   input  logic                   reset,
   // input word channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [VALUE_WIDTH-1:0] req_value,
   // result word channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [CHAR_W-1:0]      rsp_char_out,
   output logic                   rsp_last_char,
   // configuration
   input  logic                   csr_write_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [TABLE_W-1:0]     csr_wdata
);

   localparam logic [RADIX_W-1:0] RADIX_CAP = RADIX_W'(MAX_RADIX);

   logic [RADIX_W-1:0]     radix_ff, radix_in;
   logic [TABLE_W-1:0]     chars_low_ff, chars_low_in;
   logic [TABLE_W-1:0]     chars_high_ff, chars_high_in;
   logic [RADIX_W-1:0]     radix_wr;
   logic                   q_valid, q_ready, q_zero;
   logic [VALUE_WIDTH-1:0] q_value;
   logic                   div_start, div_done;
   logic [VALUE_WIDTH-1:0] div_dividend, div_quot;
   logic [DIGIT_W-1:0]     div_rem;

   // register writes, radix clamped into its legal range
   always_comb begin
      radix_wr = csr_wdata[RADIX_W-1:0];
      if (radix_wr < MIN_RADIX) begin
         radix_wr = MIN_RADIX;
      end else if (radix_wr > RADIX_CAP) begin
         radix_wr = RADIX_CAP;
      end
      radix_in      = radix_ff;
      chars_low_in  = chars_low_ff;
      chars_high_in = chars_high_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_RADIX:      radix_in      = radix_wr;
            CSR_CHARS_LOW:  chars_low_in  = csr_wdata;
            CSR_CHARS_HIGH: chars_high_in = csr_wdata;
            default: begin
               radix_in = radix_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff      <= RESET_RADIX;
         chars_low_ff  <= RESET_CHARS_LOW;
         chars_high_ff <= RESET_CHARS_HIGH;
      end else begin
         radix_ff      <= radix_in;
         chars_low_ff  <= chars_low_in;
         chars_high_ff <= chars_high_in;
      end
   end

   rdse_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_value (req_value),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_value   (q_value),
      .q_zero    (q_zero)
   );

   rdse_divider #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .radix     (radix_ff),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   rdse_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_ready       (q_ready),
      .q_value       (q_value),
      .q_zero        (q_zero),
      .div_start     (div_start),
      .div_dividend  (div_dividend),
      .div_done      (div_done),
      .div_quot      (div_quot),
      .div_rem       (div_rem),
      .chars_low     (chars_low_ff),
      .chars_high    (chars_high_ff),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_out  (rsp_char_out),
      .rsp_last_char (rsp_last_char)
   );

endmodule

// ----- sim/tb_radix_digit_string_encoder.sv -----
module tb_radix_digit_string_encoder;
   import rdse_pkg::*;

   localparam int VALUE_W    = DEFAULT_VALUE_WIDTH;
   localparam int MAX_DIGITS = 32;
   localparam int TEXT_W     = 8 * MAX_DIGITS;
   localparam int HANG_LIMIT = 4000;
   localparam int PHASES     = 12;
   localparam int PHASE_WORDS = 26;
   localparam int DIR_ROWS   = 30;

   // Index with no register behind it; writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } char_word_type;

   typedef enum logic {ROW_CSR, ROW_WORD} row_kind_type;

   // One row of the directed table; want = 0 means use the predictor
   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] idx;
      logic [TABLE_W-1:0]   data;
      logic [TEXT_W-1:0]    want;
   } stim_row_type;

   typedef enum logic [1:0] {
      IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH
   } idle_mode_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [VALUE_W-1:0]   req_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [CHAR_W-1:0]    rsp_char_out;
   logic                 rsp_last_char;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [TABLE_W-1:0]   csr_wdata = '0;

   // Mirror of the block's configuration
   int unsigned        base_now   = RESET_RADIX;
   logic [TABLE_W-1:0] glyphs_low  = RESET_CHARS_LOW;
   logic [TABLE_W-1:0] glyphs_high = RESET_CHARS_HIGH;

   char_word_type pending_chars[$];
   stim_row_type  directed [DIR_ROWS];

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int error_count   = 0;
   int words_sent    = 0;
   int chars_checked = 0;
   int radix_writes  = 0;
   int quiet_cycles  = 0;

   radix_digit_string_encoder u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_out  (rsp_char_out),
      .rsp_last_char (rsp_last_char),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #5 clock = ~clock;

   // Expected characters of one number: repeated division, then MSD first
   function automatic void predict_chars(input logic [VALUE_W-1:0] v);
      logic [3:0]          digits [MAX_DIGITS];
      logic [2*TABLE_W-1:0] glyphs;
      logic [VALUE_W-1:0]  q;
      int                  n;
      char_word_type       w;
      glyphs = {glyphs_high, glyphs_low};
      q = v;
      n = 0;
      if (q == '0) begin
         w.ch = ZERO_CHAR;
         w.last = 1'b1;
         pending_chars.push_back(w);
         return;
      end
      while (q != '0 && n < MAX_DIGITS) begin
         digits[n] = 4'(q % base_now);
         q = q / base_now;
         n++;
      end
      for (int k = n - 1; k >= 0; k--) begin
         w.ch = glyphs[{digits[k], 3'b000} +: CHAR_W];
         w.last = (k == 0);
         pending_chars.push_back(w);
      end
   endfunction

   // Typed-in text, right-justified, leading NUL bytes skipped
   function automatic void push_text(input logic [TEXT_W-1:0] txt);
      int            top;
      char_word_type w;
      top = MAX_DIGITS - 1;
      while (top > 0 && txt[top*8 +: 8] == 8'h00) top--;
      for (int i = top; i >= 0; i--) begin
         w.ch = txt[i*8 +: 8];
         w.last = (i == 0);
         pending_chars.push_back(w);
      end
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      logic [VALUE_W-1:0] v;
      int                 bitpos;
      bitpos = $urandom_range(0, VALUE_W - 1);
      case ($urandom_range(0, 9))
         0: v = '0;
         1: v = VALUE_W'($urandom_range(1, 300));
         2: v = '1 - VALUE_W'($urandom_range(0, 300));
         3: v = VALUE_W'(1) << bitpos;
         4: v = (VALUE_W'(1) << bitpos) - VALUE_W'(1);
         default: v = VALUE_W'($urandom);
      endcase
      return v;
   endfunction

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
         IDLE_SENDER:   begin send_idle_pct = 48; stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 48; end
         default:       begin send_idle_pct = 6;  stall_pct = 6;  end
      endcase
   endtask

   // Entered and left at a falling edge
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [TABLE_W-1:0] data);
      logic [4:0] r;
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_RADIX: begin
            r = data[4:0];
            if (r < MIN_RADIX) r = MIN_RADIX;
            if (r > 5'(DEFAULT_MAX_RADIX)) r = 5'(DEFAULT_MAX_RADIX);
            base_now = r;
            radix_writes++;
         end
         CSR_CHARS_LOW:  glyphs_low = data;
         CSR_CHARS_HIGH: glyphs_high = data;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Offer one word, hold it until taken, then record what it should produce
   task automatic send_word(input logic [VALUE_W-1:0] v, input logic [TEXT_W-1:0] want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (req_stall);
      if (want != '0) push_text(want);
      else predict_chars(v);
      words_sent++;
      @(negedge clock);
   endtask

   // Stop sending and let every expected character come out
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_chars.size() != 0) @(negedge clock);
   endtask

   // Receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
   end

   // Result checker
   always @(posedge clock) begin : check_chars
      char_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_chars.size() == 0) begin
            $error("unexpected word: char_out %h last_char %b", rsp_char_out, rsp_last_char);
            error_count++;
         end else begin
            want = pending_chars.pop_front();
            chars_checked++;
            if (rsp_char_out !== want.ch) begin
               $error("char_out: expected %h, got %h", want.ch, rsp_char_out);
               error_count++;
            end
            if (rsp_last_char !== want.last) begin
               $error("last_char: expected %b, got %b", want.last, rsp_last_char);
               error_count++;
            end
         end
      end
   end

   // Hang detection: cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= HANG_LIMIT) begin
            $display("timeout with %0d characters outstanding", pending_chars.size());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      logic [TABLE_W-1:0] data;

      // Directed rows: known strings after reset, radix extremes and clamps,
      // zero with a foreign table, a write to an unused index
      directed = '{
         '{ROW_WORD, CSR_RADIX, 64'h0, TEXT_W'("0")},
         '{ROW_WORD, CSR_RADIX, 64'hFFFF_FFFF, TEXT_W'("4294967295")},
         '{ROW_WORD, CSR_RADIX, 64'h1, TEXT_W'("1")},
         '{ROW_WORD, CSR_RADIX, 64'd10, TEXT_W'("10")},
         '{ROW_CSR, CSR_RADIX, 64'd16, TEXT_W'(0)},
         '{ROW_WORD, CSR_RADIX, 64'hFFFF_FFFF, TEXT_W'("ffffffff")},
         '{ROW_WORD, CSR_RADIX, 64'h8000_0000, TEXT_W'("80000000")},
         '{ROW_WORD, CSR_RADIX, 64'h0123_ABCD, TEXT_W'("123abcd")},
         '{ROW_CSR, CSR_RADIX, 64'd0, TEXT_W'(0)},
         '{ROW_WORD, CSR_RADIX, 64'hFFFF_FFFF, TEXT_W'("11111111111111111111111111111111")},
         '{ROW_WORD, CSR_RADIX, 64'h8000_0000, TEXT_W'("10000000000000000000000000000000")},
         '{ROW_WORD, CSR_RADIX, 64'd5, TEXT_W'("101")},
         '{ROW_CSR, CSR_RADIX, 64'd31, TEXT_W'(0)},
         '{ROW_WORD, CSR_RADIX, 64'd255, TEXT_W'("ff")},
         '{ROW_CSR, CSR_RADIX, 64'hFFFF_FFFF_FFFF_FFE3, TEXT_W'(0)},
         '{ROW_WORD, CSR_RADIX, 64'hFFFF_FFFF, TEXT_W'(0)},
         '{ROW_WORD, CSR_RADIX, 64'd3, TEXT_W'("10")},
         '{ROW_CSR, CSR_RADIX, 64'd1, TEXT_W'(0)},
         '{ROW_WORD, CSR_RADIX, 64'd2, TEXT_W'("10")},
         '{ROW_CSR, CSR_RADIX, 64'd16, TEXT_W'(0)},
         '{ROW_CSR, CSR_CHARS_LOW, 64'h4746_4544_4342_4140, TEXT_W'(0)},
         '{ROW_CSR, CSR_CHARS_HIGH, 64'h4F4E_4D4C_4B4A_4948, TEXT_W'(0)},
         '{ROW_WORD, CSR_RADIX, 64'h0, TEXT_W'("0")},
         '{ROW_WORD, CSR_RADIX, 64'hFFFF_FFFF, TEXT_W'("OOOOOOOO")},
         '{ROW_WORD, CSR_RADIX, 64'h89AB_CDEF, TEXT_W'("HIJKLMNO")},
         '{ROW_WORD, CSR_RADIX, 64'h0123_4567, TEXT_W'("ABCDEFG")},
         '{ROW_CSR, CSR_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, TEXT_W'(0)},
         '{ROW_WORD, CSR_RADIX, 64'h10, TEXT_W'("A@")},
         '{ROW_CSR, CSR_RADIX, 64'd7, TEXT_W'(0)},
         '{ROW_WORD, CSR_RADIX, 64'h1234_5678, TEXT_W'(0)}
      };

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed walk; register writes only once the block has emptied
      set_idling(IDLE_NONE);
      for (int i = 0; i < DIR_ROWS; i++) begin
         if (directed[i].kind == ROW_CSR) begin
            drain();
            write_csr(directed[i].idx, directed[i].data);
         end else begin
            send_word(directed[i].data[VALUE_W-1:0], directed[i].want);
         end
      end

      // Random phases: new radix and table each time, idling pattern rotates
      for (int p = 0; p < PHASES; p++) begin
         drain();
         data = {$urandom, $urandom};
         if (p == 0) data[4:0] = 5'd2;
         else if (p == 1) data[4:0] = 5'(DEFAULT_MAX_RADIX);
         else if ($urandom_range(0, 3) != 0) data[4:0] = 5'($urandom_range(2, 16));
         write_csr(CSR_RADIX, data);
         if (p == 2) begin
            write_csr(CSR_CHARS_LOW, '0);
            write_csr(CSR_CHARS_HIGH, '1);
         end else if (p == 3) begin
            write_csr(CSR_CHARS_LOW, '1);
            write_csr(CSR_CHARS_HIGH, '0);
         end else if (p % 5 == 4) begin
            write_csr(CSR_CHARS_LOW, RESET_CHARS_LOW);
            write_csr(CSR_CHARS_HIGH, RESET_CHARS_HIGH);
         end else begin
            write_csr(CSR_CHARS_LOW, {$urandom, $urandom});
            write_csr(CSR_CHARS_HIGH, {$urandom, $urandom});
         end
         if ($urandom_range(0, 2) == 0) write_csr(CSR_UNUSED, {$urandom, $urandom});
         set_idling(idle_mode_type'(p % 4));
         for (int j = 0; j < PHASE_WORDS; j++) send_word(pick_value(), '0);
      end

      drain();
      set_idling(IDLE_NONE);
      repeat (40) @(negedge clock);

      $display("Converted %0d numbers into %0d checked characters", words_sent, chars_checked);
      $display("across %0d radix writes, clamped radixes and varied digit tables",
               radix_writes);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
